@@ rtl/ldv_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the layout descriptor validator
// no dependencies; imported by every module of the block
package ldv_pkg;

    localparam int WORD_W    = 64;
    localparam int WC_W      = 17;
    localparam int ROWS_W    = 48;
    localparam int CODE_W    = 8;
    localparam int VERD_W    = 4;
    localparam int UNIT_W    = 14;
    localparam int CFG_IDX_W = 2;

    localparam int LDV_MAX_WORDS = 65536;

    // register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_CODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_CODE = 2'd2;

    localparam logic [CODE_W-1:0] FLAT_CODE_RST  = 8'd0;
    localparam logic [CODE_W-1:0] GROUP_CODE_RST = 8'd1;

    typedef enum logic [VERD_W-1:0] {
        V_PENDING     = 4'd0,
        V_VALID       = 4'd1,
        V_SHORT       = 4'd2,
        V_GRAN        = 4'd3,
        V_NOUNITS     = 4'd4,
        V_TRAIL_EMPTY = 4'd5,
        V_COUNT       = 4'd6,
        V_TRUNC_UNIT  = 4'd7,
        V_RANGE       = 4'd8,
        V_TRUNC_SEG   = 4'd9,
        V_TRAIL       = 4'd10
    } t_verdict;

    typedef struct packed {
        logic [ROWS_W-1:0] file_rows;
        logic [CODE_W-1:0] flat_code;
        logic [CODE_W-1:0] group_code;
    } t_cfg;

    typedef struct packed {
        t_verdict          verdict;
        logic              final_res;
        logic [UNIT_W-1:0] unit_at_fault;
    } t_result;

endpackage

@@ rtl/ldv_cfg_regs.sv @@
`timescale 1ns / 1ps
// configuration registers: file row count and the two granularity codes
// depends on ldv_pkg
module ldv_cfg_regs
    import ldv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [CFG_IDX_W-1:0] i_index,
    input  logic [ROWS_W-1:0]    i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.file_rows  <= '0;
            r_cfg.flat_code  <= FLAT_CODE_RST;
            r_cfg.group_code <= GROUP_CODE_RST;
        end else if (i_wr) begin
            // writes to an unused index are dropped
            unique case (i_index)
                CFG_FILE_ROWS:  r_cfg.file_rows  <= i_data;
                CFG_FLAT_CODE:  r_cfg.flat_code  <= i_data[CODE_W-1:0];
                CFG_GROUP_CODE: r_cfg.group_code <= i_data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/ldv_parser.sv @@
`timescale 1ns / 1ps
// per-word parser: layout state and the verdict for one word per cycle while i_fire is high
// depends on ldv_pkg
module ldv_parser
    import ldv_pkg::*;
#(
    parameter int MAX_WORDS = LDV_MAX_WORDS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [WORD_W-1:0] i_word,
    input  logic [WC_W-1:0]   i_word_count,
    input  t_cfg              i_cfg,
    output t_result           o_res
);

    localparam int CNT_W = (MAX_WORDS >= 2**WC_W - 1) ? WC_W : $clog2(MAX_WORDS + 1);
    localparam int UL_W  = (CNT_W > 2) ? CNT_W - 2 : 1;
    localparam logic [24:0] MAX_V = 25'(MAX_WORDS);

    typedef enum logic [2:0] {
        S_GRAN   = 3'd0,
        S_COUNT  = 3'd1,
        S_INDEX  = 3'd2,
        S_OFFSET = 3'd3,
        S_ROWS   = 3'd4,
        S_NSEG   = 3'd5,
        S_SEGS   = 3'd6,
        S_DONE   = 3'd7
    } t_slot;

    logic [CNT_W-1:0]  r_position, n_position;
    logic [CNT_W-1:0]  r_total, n_total;
    logic [UL_W-1:0]   r_units_left, n_units_left;
    logic [UNIT_W-1:0] r_unit_number, n_unit_number;
    t_slot             r_slot, n_slot;
    logic [CNT_W-1:0]  r_segs_left, n_segs_left;
    logic [WORD_W-1:0] r_held_offset, n_held_offset;
    t_verdict          r_verdict, n_verdict;
    logic [UNIT_W-1:0] r_fault_unit, n_fault_unit;

    logic [CNT_W-1:0]  cur_t;
    logic [CNT_W-1:0]  rem;
    logic [CNT_W-1:0]  max_units;
    logic [WORD_W:0]   row_end;
    logic              last;
    logic              seg_fit;
    logic [CNT_W-1:0]  segs_dec;
    logic [UL_W-1:0]   ul_dec;
    t_result           res;

    // the word count is taken only on the first word of a layout
    always_comb begin
        if (r_position != '0) begin
            cur_t = r_total;
        end else if ({8'd0, i_word_count} > MAX_V) begin
            cur_t = CNT_W'(MAX_WORDS);
        end else begin
            cur_t = i_word_count[CNT_W-1:0];
        end
    end

    assign rem       = cur_t - r_position;
    assign max_units = (cur_t - CNT_W'(2)) >> 2;
    assign row_end   = {1'b0, r_held_offset} + {1'b0, i_word};
    assign last      = ({1'b0, r_position} + (CNT_W+1)'(1)) == {1'b0, cur_t};
    assign seg_fit   = (i_word[WORD_W-1:CNT_W] == '0)
                       && (i_word[CNT_W-1:0] <= rem - CNT_W'(1));
    assign segs_dec  = (r_segs_left != '0) ? r_segs_left - CNT_W'(1) : r_segs_left;
    assign ul_dec    = (r_units_left != '0) ? r_units_left - UL_W'(1) : r_units_left;

    always_comb begin
        n_position    = r_position;
        n_total       = cur_t;
        n_units_left  = r_units_left;
        n_unit_number = r_unit_number;
        n_slot        = r_slot;
        n_segs_left   = r_segs_left;
        n_held_offset = r_held_offset;
        n_verdict     = r_verdict;
        n_fault_unit  = r_fault_unit;
        res           = '{verdict: V_PENDING, final_res: 1'b0, unit_at_fault: '0};

        if ((CNT_W+1)'(cur_t) < (CNT_W+1)'(2)) begin
            // empty or one-word layout
            res.verdict   = V_SHORT;
            res.final_res = 1'b1;
        end else begin
            if (r_verdict == V_PENDING) begin
                unique case (r_slot)
                    S_GRAN: begin
                        if (i_word != WORD_W'(i_cfg.flat_code)
                                && i_word != WORD_W'(i_cfg.group_code)) begin
                            n_verdict = V_GRAN;
                        end else begin
                            n_slot = S_COUNT;
                        end
                    end
                    S_COUNT: begin
                        priority if (i_word == '0) begin
                            priority if (i_cfg.file_rows != '0) begin
                                n_verdict = V_NOUNITS;
                            end else if (cur_t != CNT_W'(2)) begin
                                n_verdict = V_TRAIL_EMPTY;
                            end else begin
                                n_slot = S_DONE;
                            end
                        end else if (i_word > WORD_W'(max_units)) begin
                            n_verdict = V_COUNT;
                        end else begin
                            n_units_left  = i_word[UL_W-1:0];
                            n_unit_number = '0;
                            n_slot        = S_INDEX;
                        end
                    end
                    S_INDEX: begin
                        if ((CNT_W+1)'(rem) < (CNT_W+1)'(4)) begin
                            n_verdict    = V_TRUNC_UNIT;
                            n_fault_unit = r_unit_number;
                        end else begin
                            n_slot = S_OFFSET;
                        end
                    end
                    S_OFFSET: begin
                        n_held_offset = i_word;
                        n_slot        = S_ROWS;
                    end
                    S_ROWS: begin
                        // offset + rows beyond the file, computed without wrap
                        if (row_end > (WORD_W+1)'(i_cfg.file_rows)) begin
                            n_verdict    = V_RANGE;
                            n_fault_unit = r_unit_number;
                        end else begin
                            n_slot = S_NSEG;
                        end
                    end
                    S_NSEG: begin
                        priority if (!seg_fit) begin
                            n_verdict    = V_TRUNC_SEG;
                            n_fault_unit = r_unit_number;
                        end else if (i_word == '0) begin
                            n_unit_number = r_unit_number + UNIT_W'(1);
                            n_units_left  = ul_dec;
                            n_slot        = (ul_dec != '0) ? S_INDEX : S_DONE;
                        end else begin
                            n_segs_left = i_word[CNT_W-1:0];
                            n_slot      = S_SEGS;
                        end
                    end
                    S_SEGS: begin
                        n_segs_left = segs_dec;
                        if (segs_dec == '0) begin
                            n_unit_number = r_unit_number + UNIT_W'(1);
                            n_units_left  = ul_dec;
                            n_slot        = (ul_dec != '0) ? S_INDEX : S_DONE;
                        end
                    end
                    S_DONE: n_verdict = V_TRAIL;
                    default: n_verdict = V_TRAIL;
                endcase
            end

            if (last && n_verdict == V_PENDING) begin
                if (n_slot == S_DONE) begin
                    n_verdict = V_VALID;
                end else begin
                    n_verdict    = V_TRUNC_UNIT;
                    n_fault_unit = n_unit_number;
                end
            end

            res.verdict   = n_verdict;
            res.final_res = last;
            if (n_verdict == V_TRUNC_UNIT || n_verdict == V_RANGE
                    || n_verdict == V_TRUNC_SEG) begin
                res.unit_at_fault = n_fault_unit;
            end
            n_position = r_position + CNT_W'(1);
        end

        // layout over: clear for the next one
        if (res.final_res) begin
            n_position    = '0;
            n_total       = '0;
            n_units_left  = '0;
            n_unit_number = '0;
            n_slot        = S_GRAN;
            n_segs_left   = '0;
            n_held_offset = '0;
            n_verdict     = V_PENDING;
            n_fault_unit  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position    <= '0;
            r_total       <= '0;
            r_units_left  <= '0;
            r_unit_number <= '0;
            r_slot        <= S_GRAN;
            r_segs_left   <= '0;
            r_held_offset <= '0;
            r_verdict     <= V_PENDING;
            r_fault_unit  <= '0;
        end else if (i_fire) begin
            r_position    <= n_position;
            r_total       <= n_total;
            r_units_left  <= n_units_left;
            r_unit_number <= n_unit_number;
            r_slot        <= n_slot;
            r_segs_left   <= n_segs_left;
            r_held_offset <= n_held_offset;
            r_verdict     <= n_verdict;
            r_fault_unit  <= n_fault_unit;
        end
    end

    assign o_res = res;

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.final_res |=> r_position == '0 && r_verdict == V_PENDING)
        else $error("layout state not cleared after final word");

    a_final_decided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.final_res |-> res.verdict != V_PENDING)
        else $error("final word left verdict pending");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position != '0 |-> r_position < r_total)
        else $error("position beyond layout length");

    a_fault_only_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.unit_at_fault != '0 |-> (res.verdict == V_TRUNC_UNIT
            || res.verdict == V_RANGE || res.verdict == V_TRUNC_SEG))
        else $error("unit index reported without a per-unit error");

endmodule

@@ rtl/layout_descriptor_validator_unit.sv @@
`timescale 1ns / 1ps
// top level of the layout descriptor validator: input and result registers
// depends on ldv_pkg, ldv_cfg_regs and ldv_parser
//
// usage:
//   s_axis carries the layout words, one 64-bit word per transaction, with the
//   layout's word count beside it; the count is sampled on the first word only.
//   m_axis returns one result per word: the sticky verdict, the faulting unit
//   index, and tlast set on the final word of a layout, where the verdict holds.
//   the cfg channel writes file_rows, flat_code and group_code; it is always
//   ready and should be used only while no word is in flight.
// timing:
//   a word accepted into the input register is parsed combinationally from it,
//   and its result is loaded into the output register once that register is
//   free; results are presented from the output register.
//   throughput is one word per cycle while m_axis_tready stays high; the parse
//   of each word is a single compare-and-update of the layout state.
// reset and stall:
//   synchronous reset clears the layout state and both stages and loads the
//   register defaults (file_rows 0, flat_code 0, group_code 1).
//   when m_axis_tready is low the result is held; one more word can wait in
//   the input register, after which s_axis_tready drops until the result moves.
module layout_descriptor_validator_unit
    import ldv_pkg::*;
#(
    parameter int MAX_WORDS = LDV_MAX_WORDS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [63:0] word, [80:64] word_count, [87:81] zero
    input  logic [87:0]          s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [3:0] verdict, [17:4] unit_at_fault, [23:18] zero
    output logic [23:0]          m_axis_tdata,
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ROWS_W-1:0]    i_cfg_data
);

    logic              r_in_valid;
    logic [WORD_W-1:0] r_in_word;
    logic [WC_W-1:0]   r_in_wc;
    logic              r_out_valid;
    t_result           r_out_res;

    t_cfg              cfg;
    t_result           res;
    logic              out_free;
    logic              adv;
    logic              in_fire;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign adv           = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    ldv_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ldv_parser #(
        .MAX_WORDS (MAX_WORDS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (adv),
        .i_word       (r_in_word),
        .i_word_count (r_in_wc),
        .i_cfg        (cfg),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_word <= s_axis_tdata[WORD_W-1:0];
            r_in_wc   <= s_axis_tdata[WORD_W+WC_W-1:WORD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_res.final_res;
    assign m_axis_tdata  = {6'd0, r_out_res.unit_at_fault, r_out_res.verdict};

endmodule
